// ===== sv/sid_pkg.sv =====
`timescale 1ns / 1ps

package sid_pkg;

  // Operand and result width of the divider.
  localparam int DATA_WIDTH = 32;

  // Width of the iteration counter: one quotient bit per step.
  localparam int CNT_W = $clog2(DATA_WIDTH);

  typedef logic [DATA_WIDTH-1:0] word_t;

  // Control from the sequencer to the iterative unit.
  typedef struct packed {
    logic load;
  } sid_iter_ctrl_t;

  // Status from the iterative unit back to the sequencer.
  typedef struct packed {
    logic active;
    logic done;
  } sid_iter_stat_t;

  // Two's complement negation, truncated to the word width.
  function automatic word_t negate(input word_t v);
    negate = ~v + word_t'(1);
  endfunction

endpackage

// ===== sv/sid_iter.sv =====
`timescale 1ns / 1ps

// Radix-2 restoring divider for unsigned magnitudes. A single subtractor is
// reused once per quotient bit, so a division takes DATA_WIDTH steps.
module sid_iter import sid_pkg::*; (
  input  logic           clk,
  input  logic           rst_n,
  input  sid_iter_ctrl_t ctrl,
  input  word_t          num_mag,
  input  word_t          den_mag,
  output sid_iter_stat_t stat,
  output word_t          quo_mag,
  output word_t          rem_mag
);

  logic             active_r, active_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  word_t            rem_r, rem_nxt;
  word_t            quo_r, quo_nxt;
  word_t            den_r, den_nxt;

  logic [DATA_WIDTH:0] trial;
  logic [DATA_WIDTH:0] diff;

  // Shift the next dividend bit into the partial remainder and try to subtract.
  assign trial = {rem_r, quo_r[DATA_WIDTH-1]};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    active_nxt = active_r;
    done_nxt   = 1'b0;
    cnt_nxt    = cnt_r;
    rem_nxt    = rem_r;
    quo_nxt    = quo_r;
    den_nxt    = den_r;
    if (ctrl.load) begin
      active_nxt = 1'b1;
      cnt_nxt    = '0;
      rem_nxt    = '0;
      quo_nxt    = num_mag;
      den_nxt    = den_mag;
    end else if (active_r) begin
      // A set top bit in the difference means the subtraction borrowed.
      if (diff[DATA_WIDTH]) begin
        rem_nxt = trial[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b0};
      end else begin
        rem_nxt = diff[DATA_WIDTH-1:0];
        quo_nxt = {quo_r[DATA_WIDTH-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DATA_WIDTH - 1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  // Control state is reset; the data registers are loaded before use.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      cnt_r    <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign stat.active = active_r;
  assign stat.done   = done_r;
  assign quo_mag     = quo_r;
  assign rem_mag     = rem_r;

endmodule

// ===== sv/signed_integer_divider.sv =====
`timescale 1ns / 1ps

// Signed 32-bit divider with truncation toward zero; the remainder takes the
// sign of the dividend. A transaction is taken when start is high and busy is
// low. An ordinary division captures the operands, forms their magnitudes in
// the prepare state, runs the radix-2 subtract-and-shift unit (one quotient
// bit per step), and applies the signs when the unit signals completion. A
// zero divisor, or the most negative value divided by -1, is settled in the
// prepare state without the unit. The result is shown for exactly one cycle
// with out_valid high and must be taken then; the receiver cannot stall it.
// busy falls in that same cycle, so the next transaction can be started while
// the result is on the ports.
module signed_integer_divider import sid_pkg::*; (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] out_quotient,
  output logic signed [DATA_WIDTH-1:0] out_remainder,
  output logic                         out_divide_by_zero,
  output logic                         out_overflow
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV
  } state_t;

  localparam word_t MOST_NEG = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t MOST_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t MINUS_ONE = {DATA_WIDTH{1'b1}};

  state_t state_r, state_nxt;
  word_t  a_r, a_nxt;
  word_t  b_r, b_nxt;
  logic   valid_r, valid_nxt;
  word_t  quo_r, quo_nxt;
  word_t  rem_r, rem_nxt;
  logic   dbz_r, dbz_nxt;
  logic   ovf_r, ovf_nxt;

  sid_iter_ctrl_t iter_ctrl;
  sid_iter_stat_t iter_stat;
  word_t          a_mag;
  word_t          b_mag;
  word_t          quo_mag;
  word_t          rem_mag;
  logic           neg_a;
  logic           neg_b;

  assign neg_a = a_r[DATA_WIDTH-1];
  assign neg_b = b_r[DATA_WIDTH-1];
  assign a_mag = neg_a ? negate(a_r) : a_r;
  assign b_mag = neg_b ? negate(b_r) : b_r;

  sid_iter u_iter (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (iter_ctrl),
    .num_mag (a_mag),
    .den_mag (b_mag),
    .stat    (iter_stat),
    .quo_mag (quo_mag),
    .rem_mag (rem_mag)
  );

  // Sequencer: capture operands, settle special cases, run the unit, fix signs.
  always_comb begin
    state_nxt      = state_r;
    a_nxt          = a_r;
    b_nxt          = b_r;
    valid_nxt      = 1'b0;
    quo_nxt        = quo_r;
    rem_nxt        = rem_r;
    dbz_nxt        = dbz_r;
    ovf_nxt        = ovf_r;
    iter_ctrl.load = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          a_nxt     = word_t'(in_dividend);
          b_nxt     = word_t'(in_divisor);
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        if (b_r == '0) begin
          valid_nxt = 1'b1;
          quo_nxt   = '0;
          rem_nxt   = a_r;
          dbz_nxt   = 1'b1;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end else if (a_r == MOST_NEG && b_r == MINUS_ONE) begin
          valid_nxt = 1'b1;
          quo_nxt   = MOST_POS;
          rem_nxt   = '0;
          dbz_nxt   = 1'b0;
          ovf_nxt   = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          iter_ctrl.load = 1'b1;
          state_nxt      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (iter_stat.done) begin
          valid_nxt = 1'b1;
          quo_nxt   = (neg_a != neg_b) ? negate(quo_mag) : quo_mag;
          rem_nxt   = neg_a ? negate(rem_mag) : rem_mag;
          dbz_nxt   = 1'b0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dbz_r <= dbz_nxt;
    ovf_r <= ovf_nxt;
  end

  assign busy               = (state_r != ST_IDLE);
  assign out_valid          = valid_r;
  assign out_quotient       = $signed(quo_r);
  assign out_remainder      = $signed(rem_r);
  assign out_divide_by_zero = dbz_r;
  assign out_overflow       = ovf_r;

`ifndef NO_ASSERTIONS
  // A result only appears once the sequencer has gone back to idle.
  a_valid_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while the divider is busy");

  // The two special cases exclude each other.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_divide_by_zero && out_overflow))
    else $error("divide-by-zero and overflow flagged together");

  // A taken transaction makes the divider busy in the next cycle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transaction taken but divider not busy");

  // The iterative unit only runs while the sequencer waits for it.
  a_unit_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    iter_stat.active |-> (state_r == ST_DIV))
    else $error("iterative unit active outside the divide state");

  // A zero divisor always gives a zero quotient.
  a_dbz_quotient: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_divide_by_zero) |-> (out_quotient == '0))
    else $error("non-zero quotient on divide-by-zero");
`endif

endmodule

// ===== sim/signed_integer_divider_tb.sv =====
`timescale 1ns / 1ps

module signed_integer_divider_tb;
  import sid_pkg::*;

  localparam word_t WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t WORD_MAX = ~WORD_MIN;
  localparam word_t MINUS_ONE = '1;
  localparam int RANDOM_DIVISIONS = 1350;
  // Quiet time at the end of the run, longer than the longest transaction.
  localparam int SETTLE_CYCLES = 40;

  typedef struct {
    word_t dividend;
    word_t divisor;
    bit    wait_idle;
  } div_request_t;

  typedef struct {
    word_t quotient;
    word_t remainder;
    logic  divide_by_zero;
    logic  overflow;
  } div_result_t;

  logic                         clk = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic signed [DATA_WIDTH-1:0] in_dividend = '0;
  logic signed [DATA_WIDTH-1:0] in_divisor = '0;
  logic                         out_valid;
  logic signed [DATA_WIDTH-1:0] out_quotient;
  logic signed [DATA_WIDTH-1:0] out_remainder;
  logic                         out_divide_by_zero;
  logic                         out_overflow;

  div_request_t pending_divisions[$];
  div_result_t  awaited_results[$];
  logic         request_taken = 1'b0;
  int           error_count = 0;
  int           burst_left = 0;
  int           idle_left = 0;

  signed_integer_divider dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_dividend        (in_dividend),
    .in_divisor         (in_divisor),
    .out_valid          (out_valid),
    .out_quotient       (out_quotient),
    .out_remainder      (out_remainder),
    .out_divide_by_zero (out_divide_by_zero),
    .out_overflow       (out_overflow)
  );

  always #6 clk = ~clk;

  // Truncating signed division on magnitudes one bit wider than a word.
  function automatic div_result_t divide_truncating(input word_t a, input word_t b);
    logic [DATA_WIDTH:0] mag_a;
    logic [DATA_WIDTH:0] mag_b;
    logic [DATA_WIDTH:0] mag_q;
    logic [DATA_WIDTH:0] mag_r;
    div_result_t res;
    res.divide_by_zero = 1'b0;
    res.overflow = 1'b0;
    if (b == '0) begin
      res.quotient = '0;
      res.remainder = a;
      res.divide_by_zero = 1'b1;
    end else if (a == WORD_MIN && b == MINUS_ONE) begin
      res.quotient = WORD_MAX;
      res.remainder = '0;
      res.overflow = 1'b1;
    end else begin
      mag_a = a[DATA_WIDTH-1] ? ({1'b0, ~a} + 1'b1) : {1'b0, a};
      mag_b = b[DATA_WIDTH-1] ? ({1'b0, ~b} + 1'b1) : {1'b0, b};
      mag_q = mag_a / mag_b;
      mag_r = mag_a % mag_b;
      res.quotient = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ?
                     word_t'(~mag_q + 1'b1) : word_t'(mag_q);
      res.remainder = a[DATA_WIDTH-1] ? word_t'(~mag_r + 1'b1) : word_t'(mag_r);
    end
    return res;
  endfunction

  // Operands drawn from several classes so that small, wide and extreme values all occur.
  function automatic word_t pick_operand();
    word_t v;
    case ($urandom_range(0, 5))
      0, 1: v = word_t'({$urandom, $urandom});
      2: v = word_t'(int'($urandom_range(0, 64)) - 32);
      3: begin
        v = word_t'({$urandom, $urandom}) >> $urandom_range(1, DATA_WIDTH - 1);
        if ($urandom_range(0, 1) == 1) v = ~v + 1'b1;
      end
      4: begin
        case ($urandom_range(0, 4))
          0: v = WORD_MIN;
          1: v = WORD_MAX;
          2: v = MINUS_ONE;
          3: v = word_t'(1);
          default: v = '0;
        endcase
      end
      default: v = word_t'(1) << $urandom_range(0, DATA_WIDTH - 1);
    endcase
    return v;
  endfunction

  task automatic queue_division(input word_t a, input word_t b, input bit wait_idle);
    div_request_t req;
    req.dividend = a;
    req.divisor = b;
    req.wait_idle = wait_idle;
    pending_divisions.push_back(req);
  endtask

  // Driver: presents the oldest pending transaction, in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst_n) begin
      if (request_taken) begin
        pending_divisions.delete(0);
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
        end else begin
          burst_left--;
        end
      end
      if (idle_left > 0) idle_left--;
      if (pending_divisions.size() > 0 && idle_left == 0 &&
          !(pending_divisions[0].wait_idle && awaited_results.size() > 0)) begin
        start <= 1'b1;
        in_dividend <= pending_divisions[0].dividend;
        in_divisor <= pending_divisions[0].divisor;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: checks each result against the oldest prediction, then records a new
  // prediction when a transaction is taken.
  always @(posedge clk) begin : monitor
    div_result_t exp_res;
    if (rst_n) begin
      if (out_valid) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no transaction outstanding: quotient %0d remainder %0d",
                   $time, out_quotient, out_remainder);
          error_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (out_quotient !== exp_res.quotient) begin
            $display("%0t: quotient mismatch: expected %0d, actual %0d",
                     $time, $signed(exp_res.quotient), out_quotient);
            error_count++;
          end
          if (out_remainder !== exp_res.remainder) begin
            $display("%0t: remainder mismatch: expected %0d, actual %0d",
                     $time, $signed(exp_res.remainder), out_remainder);
            error_count++;
          end
          if (out_divide_by_zero !== exp_res.divide_by_zero) begin
            $display("%0t: divide_by_zero mismatch: expected %0b, actual %0b",
                     $time, exp_res.divide_by_zero, out_divide_by_zero);
            error_count++;
          end
          if (out_overflow !== exp_res.overflow) begin
            $display("%0t: overflow mismatch: expected %0b, actual %0b",
                     $time, exp_res.overflow, out_overflow);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        awaited_results.push_back(divide_truncating(in_dividend, in_divisor));
      end
    end
    request_taken <= rst_n && start && !busy;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  // Stimulus and end of run.
  initial begin
    int    i;
    word_t a;
    word_t b;

    // Directed cases: zero divisors, the overflowing quotient, extremes and all sign mixes.
    queue_division(WORD_MAX, '0, 1'b0);
    queue_division(WORD_MIN, '0, 1'b0);
    queue_division('0, '0, 1'b0);
    queue_division(MINUS_ONE, '0, 1'b0);
    queue_division(WORD_MIN, MINUS_ONE, 1'b0);
    queue_division(WORD_MIN, word_t'(1), 1'b0);
    queue_division(WORD_MIN, WORD_MIN, 1'b0);
    queue_division(WORD_MAX, WORD_MAX, 1'b0);
    queue_division(WORD_MAX, WORD_MIN, 1'b0);
    queue_division(WORD_MIN, WORD_MAX, 1'b0);
    queue_division(word_t'(7), word_t'(2), 1'b0);
    queue_division(word_t'(-7), word_t'(2), 1'b0);
    queue_division(word_t'(7), word_t'(-2), 1'b0);
    queue_division(word_t'(-7), word_t'(-2), 1'b0);
    queue_division('0, word_t'(5), 1'b0);
    queue_division(word_t'(5), word_t'(7), 1'b0);
    queue_division(word_t'(1), WORD_MAX, 1'b0);
    queue_division(MINUS_ONE, MINUS_ONE, 1'b0);
    queue_division(WORD_MAX, MINUS_ONE, 1'b0);
    queue_division(WORD_MIN, word_t'(2), 1'b0);
    queue_division(WORD_MAX, word_t'(1), 1'b0);
    queue_division(MINUS_ONE, WORD_MIN, 1'b0);

    // Random divisions; now and then the sender holds off until the block has drained.
    for (i = 0; i < RANDOM_DIVISIONS; i++) begin
      a = pick_operand();
      b = pick_operand();
      if ($urandom_range(0, 19) == 0) b = '0;
      if ($urandom_range(0, 49) == 0) begin
        a = WORD_MIN;
        b = MINUS_ONE;
      end
      queue_division(a, b, (i % 300) == 0);
    end

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_divisions.size() > 0 || awaited_results.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (awaited_results.size() > 0) begin
      $display("%0t: %0d results never arrived", $time, awaited_results.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sid_pkg.sv
sv/sid_iter.sv
sv/signed_integer_divider.sv
sim/signed_integer_divider_tb.sv
